>>> sv/cds_pkg.sv
// Shared types and constants for the conservative DVFS stepper.
// Holds the configuration record, the queued sample record and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package cds_pkg;

    localparam int FIELD_W   = 23;
    localparam int LOAD_W    = 7;
    localparam int PCT_W     = 7;
    localparam int IDLE_W    = 16;
    localparam int DF_W      = 4;
    localparam int CFG_IDX_W = 3;

    localparam int PCT_FULL      = 100;
    localparam int FALLBACK_STEP = 5;
    localparam int SKIP_MAX      = 15;

    // Reciprocal of 25 scaled by 2^33; exact for dividends below 2^28.
    localparam int                      DIV25_MUL_W = 29;
    localparam logic [DIV25_MUL_W-1:0]  DIV25_MUL   = 29'd343597384;
    localparam int                      DIV25_SHIFT = 33;

    localparam logic [PCT_W-1:0]   RST_UP_THR      = PCT_W'(80);
    localparam logic [PCT_W-1:0]   RST_DOWN_THR    = PCT_W'(20);
    localparam logic [PCT_W-1:0]   RST_STEP_PCT    = PCT_W'(5);
    localparam logic [DF_W-1:0]    RST_DOWN_FACTOR = DF_W'(1);
    localparam logic [FIELD_W-1:0] RST_MIN_FREQ    = '0;
    localparam logic [FIELD_W-1:0] RST_MAX_FREQ    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_THR,
        REG_DOWN_THR,
        REG_STEP_PCT,
        REG_DOWN_FACTOR,
        REG_MIN_FREQ,
        REG_MAX_FREQ
    } t_reg_idx;

    typedef struct packed {
        logic [PCT_W-1:0]   up_thr;
        logic [PCT_W-1:0]   down_thr;
        logic [PCT_W-1:0]   step_pct;
        logic [DF_W-1:0]    down_factor;
        logic [FIELD_W-1:0] min_freq;
        logic [FIELD_W-1:0] max_freq;
    } t_cfg;

    typedef struct packed {
        logic [LOAD_W-1:0]  load;
        logic [FIELD_W-1:0] cur;
        logic [IDLE_W-1:0]  idle;
        logic               is_up;
        logic               is_low;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DROP,
        S_ADJ,
        S_DEC
    } t_state;

endpackage

>>> sv/cds_front.sv
// Front end of the DVFS stepper: accepts load samples, classifies them against
// the thresholds and holds them in a two-entry queue for the back end.
// Depends on cds_pkg.
`timescale 1ns / 1ps

module cds_front import cds_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [LOAD_W-1:0]  i_load_pct,
    input  logic [FIELD_W-1:0] i_current_freq,
    input  logic [IDLE_W-1:0]  i_idle_periods,
    output logic               o_q_valid,
    output t_item              o_q_item,
    input  logic               i_q_take
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic        w_push;
    logic        w_pop;
    t_item       w_item;

    always_comb begin
        w_item.load   = i_load_pct;
        w_item.cur    = i_current_freq;
        w_item.idle   = i_idle_periods;
        w_item.is_up  = i_load_pct > i_cfg.up_thr;
        w_item.is_low = i_load_pct < i_cfg.down_thr;
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = i_q_take && o_q_valid;
    assign o_q_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

>>> sv/cds_back.sv
// Back end of the DVFS stepper: a sequencer that loads the request, derives the
// step with a reciprocal divide by 100, applies idle drops and decides the result.
// Depends on cds_pkg.
`timescale 1ns / 1ps

module cds_back import cds_pkg::*; #(
    parameter int FREQ_BITS = 23
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    output logic               o_q_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_set_target,
    output logic [FIELD_W-1:0] o_target_freq,
    output logic               o_round_down
);

    localparam int FW = (FREQ_BITS < FIELD_W) ? FREQ_BITS : FIELD_W;
    localparam int PW = PCT_W + FW;
    localparam int DW = IDLE_W + FW;
    localparam int RW = PW - 2 + DIV25_MUL_W;

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic               r_started, n_started;
    logic [FW-1:0]      r_req, n_req;
    logic [DF_W-1:0]    r_skip, n_skip;
    logic [FW-1:0]      r_work, n_work;
    logic               r_frz, n_frz;
    logic [PW-1:0]      r_prod, n_prod;
    logic [FW-1:0]      r_quo, n_quo;
    logic [FW-1:0]      r_step, n_step;
    logic [DW-1:0]      r_drop, n_drop;
    logic               r_ovalid, n_ovalid;
    logic               r_oset, n_oset;
    logic [FIELD_W-1:0] r_otgt, n_otgt;
    logic               r_ord, n_ord;

    logic [FW-1:0]      w_cur, w_min, w_max, w_req0, w_req1, w_step, w_res;
    logic [PCT_W-1:0]   w_pct;
    logic [RW-1:0]      w_recip;
    logic [DW:0]        w_floor;
    logic [FW:0]        w_up;
    logic [DF_W-1:0]    w_cnt1;
    logic               w_out_free;

    assign w_cur = r_item.cur[FW-1:0];
    assign w_min = i_cfg.min_freq[FW-1:0];
    assign w_max = i_cfg.max_freq[FW-1:0];
    assign w_pct = (i_cfg.step_pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : i_cfg.step_pct;

    // The first sample after reset seeds the request from the running frequency.
    assign w_req0 = r_started ? r_req : w_cur;
    assign w_req1 = (w_req0 > w_max || w_req0 < w_min) ? w_cur : w_req0;

    // The product stays below 100 * 2^23, so a quarter of it divided by 25 through
    // the scaled reciprocal gives the exact quotient by 100.
    assign w_recip = RW'(r_prod[PW-1:2]) * RW'(DIV25_MUL);
    assign w_step  = (r_quo == '0) ? FW'(FALLBACK_STEP) : r_quo;
    assign w_floor = (DW+1)'(w_min) + (DW+1)'(r_drop);
    assign w_up    = (FW+1)'(r_work) + (FW+1)'(r_step);
    assign w_cnt1  = (r_skip == DF_W'(SKIP_MAX)) ? DF_W'(SKIP_MAX) : r_skip + DF_W'(1);

    assign w_out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_started = r_started;
        n_req     = r_req;
        n_skip    = r_skip;
        n_work    = r_work;
        n_frz     = r_frz;
        n_prod    = r_prod;
        n_quo     = r_quo;
        n_step    = r_step;
        n_drop    = r_drop;
        n_ovalid  = r_ovalid && i_out_stall;
        n_oset    = r_oset;
        n_otgt    = r_otgt;
        n_ord     = r_ord;
        o_q_take  = 1'b0;
        w_res     = r_work;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_take = 1'b1;
                    n_item   = i_q_item;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                n_started = 1'b1;
                if (!r_started) begin
                    n_skip = '0;
                end
                if (i_cfg.step_pct == '0) begin
                    n_req   = w_req0;
                    n_frz   = 1'b1;
                    n_state = S_DEC;
                end else begin
                    n_req   = w_req1;
                    n_work  = w_req1;
                    n_frz   = 1'b0;
                    n_prod  = PW'(w_pct) * PW'(w_max);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo   = w_recip[DIV25_SHIFT +: FW];
                n_state = S_DROP;
            end
            S_DROP: begin
                n_step  = w_step;
                n_drop  = DW'(r_item.idle) * DW'(w_step);
                n_state = S_ADJ;
            end
            S_ADJ: begin
                if (r_item.idle != '0) begin
                    if ((DW+1)'(r_work) > w_floor) begin
                        n_work = r_work - r_drop[FW-1:0];
                    end else begin
                        n_work = w_min;
                    end
                end
                n_state = S_DEC;
            end
            S_DEC: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_oset   = 1'b0;
                    n_otgt   = '0;
                    n_ord    = 1'b0;
                    if (!r_frz) begin
                        if (r_item.is_up) begin
                            n_skip = '0;
                            if (r_work != w_max) begin
                                w_res  = (w_up > (FW+1)'(w_max)) ? w_max : w_up[FW-1:0];
                                n_req  = w_res;
                                n_oset = 1'b1;
                                n_otgt = FIELD_W'(w_res);
                            end
                        end else begin
                            if (w_cnt1 < i_cfg.down_factor) begin
                                n_skip = w_cnt1;
                            end else begin
                                n_skip = '0;
                                if (r_item.is_low && r_work != w_min) begin
                                    w_res  = (r_work > r_step) ? r_work - r_step : w_min;
                                    n_req  = w_res;
                                    n_oset = 1'b1;
                                    n_otgt = FIELD_W'(w_res);
                                    n_ord  = 1'b1;
                                end
                            end
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_req     <= '0;
            r_skip    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_req     <= n_req;
            r_skip    <= n_skip;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_work <= n_work;
        r_frz  <= n_frz;
        r_prod <= n_prod;
        r_quo  <= n_quo;
        r_step <= n_step;
        r_drop <= n_drop;
        r_oset <= n_oset;
        r_otgt <= n_otgt;
        r_ord  <= n_ord;
    end

    assign o_out_valid   = r_ovalid;
    assign o_set_target  = r_oset;
    assign o_target_freq = r_otgt;
    assign o_round_down  = r_ord;

endmodule

>>> sv/conservative_dvfs_stepper.sv
// Conservative DVFS stepper: one load sample in, one frequency decision out. Samples
// enter a two-entry queue and are worked off one at a time by the back end. A sample
// passes the back end in these steps: take, step scaling multiply, reciprocal divide by
// 100, idle drop multiply, idle adjust and decide; with step_percent at zero a sample
// goes from take and load straight to decide. The result waits in an output register,
// so the back end can start the next sample while the previous result is stalled.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data and
// must only be changed while no transaction is in flight.
// Depends on cds_pkg, cds_front and cds_back.
`timescale 1ns / 1ps

module conservative_dvfs_stepper import cds_pkg::*; #(
    parameter int FREQ_BITS = 23
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIELD_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [LOAD_W-1:0]    i_load_pct,
    input  logic [FIELD_W-1:0]   i_current_freq,
    input  logic [IDLE_W-1:0]    i_idle_periods,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_set_target,
    output logic [FIELD_W-1:0]   o_target_freq,
    output logic                 o_round_down
);

    t_cfg  r_cfg;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_thr      <= RST_UP_THR;
            r_cfg.down_thr    <= RST_DOWN_THR;
            r_cfg.step_pct    <= RST_STEP_PCT;
            r_cfg.down_factor <= RST_DOWN_FACTOR;
            r_cfg.min_freq    <= RST_MIN_FREQ;
            r_cfg.max_freq    <= RST_MAX_FREQ;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_UP_THR:      r_cfg.up_thr      <= i_cfg_data[PCT_W-1:0];
                REG_DOWN_THR:    r_cfg.down_thr    <= i_cfg_data[PCT_W-1:0];
                REG_STEP_PCT:    r_cfg.step_pct    <= i_cfg_data[PCT_W-1:0];
                REG_DOWN_FACTOR: r_cfg.down_factor <= i_cfg_data[DF_W-1:0];
                REG_MIN_FREQ:    r_cfg.min_freq    <= i_cfg_data;
                REG_MAX_FREQ:    r_cfg.max_freq    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cds_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_load_pct     (i_load_pct),
        .i_current_freq (i_current_freq),
        .i_idle_periods (i_idle_periods),
        .o_q_valid      (w_q_valid),
        .o_q_item       (w_q_item),
        .i_q_take       (w_q_take)
    );

    cds_back #(
        .FREQ_BITS (FREQ_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_take      (w_q_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_set_target  (o_set_target),
        .o_target_freq (o_target_freq),
        .o_round_down  (o_round_down)
    );

    // A result that requests nothing carries all-zero fields.
    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_set_target) |-> (o_target_freq == '0 && !o_round_down))
        else $error("result without a request carries nonzero fields");

    // An accepted transaction always leaves the queue non-empty on the next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_q_valid)
        else $error("accepted transaction missing from the queue");

    // The back end takes at most one queued sample before it becomes busy.
    a_single_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_take |=> !w_q_take)
        else $error("back end took two samples in a row");

endmodule

>>> bench/conservative_dvfs_stepper_tb.sv
// Self-checking testbench for the conservative DVFS stepper.
// Predicts each frequency decision from a local model of the governor and checks it.
// Depends on cds_pkg and conservative_dvfs_stepper.
`timescale 1ns / 1ps

module conservative_dvfs_stepper_tb;
    import cds_pkg::*;

    localparam longint unsigned FREQ_MASK = (64'd1 << FIELD_W) - 1;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_SAMPLES = 210;

    typedef struct packed {
        logic               set_target;
        logic [FIELD_W-1:0] target_freq;
        logic               round_down;
    } t_decision;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [FIELD_W-1:0]   i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [LOAD_W-1:0]    i_load_pct = '0;
    logic [FIELD_W-1:0]   i_current_freq = '0;
    logic [IDLE_W-1:0]    i_idle_periods = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_set_target;
    logic [FIELD_W-1:0]   o_target_freq;
    logic                 o_round_down;

    // Governor shadow: configuration and state as the block should hold them.
    t_cfg               gov_cfg;
    logic [FIELD_W-1:0] gov_req;
    logic [DF_W-1:0]    gov_skip;
    logic               gov_started;

    t_decision expected_decisions[$];

    int errors = 0;
    int samples_sent = 0;
    int requests_seen = 0;
    int settings_used = 0;

    // Idling controls, changed per phase.
    int gap_max = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int stall_run_max = 1;
    int stall_left = 0;
    logic stall_now = 1'b0;

    conservative_dvfs_stepper dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_load_pct     (i_load_pct),
        .i_current_freq (i_current_freq),
        .i_idle_periods (i_idle_periods),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_set_target   (o_set_target),
        .o_target_freq  (o_target_freq),
        .o_round_down   (o_round_down)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Works out the decision for one sample and advances the shadow state.
    function automatic t_decision govern_sample(logic [LOAD_W-1:0] load,
                                                logic [FIELD_W-1:0] cur,
                                                logic [IDLE_W-1:0] idle);
        t_decision       d;
        longint unsigned req, step, pct, drop, cnt, lo, hi;
        d = '0;
        lo = gov_cfg.min_freq;
        hi = gov_cfg.max_freq;
        if (!gov_started) begin
            gov_req = cur;
            gov_skip = '0;
            gov_started = 1'b1;
        end
        if (gov_cfg.step_pct != 0) begin
            if (gov_req > hi || gov_req < lo) begin
                gov_req = cur;
            end
            req = gov_req;
            pct = (gov_cfg.step_pct > PCT_FULL) ? PCT_FULL : gov_cfg.step_pct;
            step = (pct * hi) / PCT_FULL;
            if (step == 0) begin
                step = FALLBACK_STEP;
            end
            // The idle drop only shapes this decision; it is not stored on its own.
            if (idle != 0) begin
                drop = idle * step;
                if (req > lo + drop) begin
                    req = req - drop;
                end else begin
                    req = lo;
                end
            end
            if (load > gov_cfg.up_thr) begin
                gov_skip = '0;
                if (req != hi) begin
                    req = req + step;
                    if (req > hi) req = hi;
                    if (req > FREQ_MASK) req = FREQ_MASK;
                    gov_req = req[FIELD_W-1:0];
                    d.set_target = 1'b1;
                    d.target_freq = req[FIELD_W-1:0];
                end
            end else begin
                cnt = gov_skip + 1;
                if (cnt > SKIP_MAX) cnt = SKIP_MAX;
                if (cnt < gov_cfg.down_factor) begin
                    gov_skip = cnt[DF_W-1:0];
                end else begin
                    gov_skip = '0;
                    if (load < gov_cfg.down_thr && req != lo) begin
                        if (req > step) begin
                            req = req - step;
                        end else begin
                            req = lo;
                        end
                        if (req > FREQ_MASK) req = FREQ_MASK;
                        gov_req = req[FIELD_W-1:0];
                        d.set_target = 1'b1;
                        d.target_freq = req[FIELD_W-1:0];
                        d.round_down = 1'b1;
                    end
                end
            end
        end
        return d;
    endfunction

    task automatic wait_idle();
        while (expected_decisions.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [FIELD_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_UP_THR:      gov_cfg.up_thr = value[PCT_W-1:0];
            REG_DOWN_THR:    gov_cfg.down_thr = value[PCT_W-1:0];
            REG_STEP_PCT:    gov_cfg.step_pct = value[PCT_W-1:0];
            REG_DOWN_FACTOR: gov_cfg.down_factor = value[DF_W-1:0];
            REG_MIN_FREQ:    gov_cfg.min_freq = value;
            REG_MAX_FREQ:    gov_cfg.max_freq = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_settings(int unsigned up, int unsigned down, int unsigned pct,
                                  int unsigned factor, int unsigned lo, int unsigned hi);
        write_reg(REG_UP_THR, FIELD_W'(up));
        write_reg(REG_DOWN_THR, FIELD_W'(down));
        write_reg(REG_STEP_PCT, FIELD_W'(pct));
        write_reg(REG_DOWN_FACTOR, FIELD_W'(factor));
        write_reg(REG_MIN_FREQ, FIELD_W'(lo));
        write_reg(REG_MAX_FREQ, FIELD_W'(hi));
        settings_used++;
    endtask

    // Presents one sample and holds it until the block takes it. Valid is left high.
    task automatic send_sample(int unsigned load, int unsigned cur, int unsigned idle);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_load_pct <= LOAD_W'(load);
        i_current_freq <= FIELD_W'(cur);
        i_idle_periods <= IDLE_W'(idle);
        do @(posedge i_clk); while (o_in_stall);
        expected_decisions.push_back(govern_sample(LOAD_W'(load), FIELD_W'(cur),
                                                   IDLE_W'(idle)));
        samples_sent++;
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Receiver back-pressure: runs of stalled and free cycles of random length.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_now = ($urandom_range(99) < stall_pct);
            stall_left = $urandom_range(1, stall_run_max);
        end
        stall_left--;
        i_out_stall <= stall_now;
    end

    always @(posedge i_clk) begin
        t_decision want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_decisions.size() == 0) begin
                $error("decision transaction with none pending: set_target %0b target_freq %0d",
                       o_set_target, o_target_freq);
                errors++;
            end else begin
                want = expected_decisions.pop_front();
                if (o_set_target !== want.set_target) begin
                    $error("set_target: expected %0b, got %0b", want.set_target, o_set_target);
                    errors++;
                end
                if (o_target_freq !== want.target_freq) begin
                    $error("target_freq: expected %0d, got %0d",
                           want.target_freq, o_target_freq);
                    errors++;
                end
                if (o_round_down !== want.round_down) begin
                    $error("round_down: expected %0b, got %0b", want.round_down, o_round_down);
                    errors++;
                end
                if (o_set_target === 1'b1) requests_seen++;
            end
        end
    end

    // First sample after reset adopts current_freq; then a step each way at reset values.
    task automatic test_first_sample();
        send_sample(50, 1000000, 0);
        send_sample(100, 0, 0);
        send_sample(0, FREQ_MASK, 0);
        send_sample(0, 12345, 65535);
        send_sample(85, 8000000, 1);
        pause_sender(1);
    endtask

    // Step percent above full scale, clamping at max, falling under one step, and
    // sitting at either bound.
    task automatic test_bounds();
        write_settings(50, 30, 127, 1, 100, 1000);
        send_sample(100, 500, 0);
        send_sample(100, 500, 0);
        send_sample(0, 500, 0);
        send_sample(0, 500, 0);
        send_sample(40, 700, 0);
        pause_sender(1);
        // Min above max: the request keeps falling back to current_freq.
        write_settings(50, 30, 100, 1, 300, 200);
        send_sample(40, 250, 0);
        send_sample(0, FREQ_MASK, 2);
        send_sample(100, 0, 0);
        pause_sender(1);
    endtask

    // A step that rounds to zero is replaced by the 5 kHz fallback.
    task automatic test_fallback_step();
        write_settings(1, 99, 1, 1, 0, 50);
        send_sample(2, 20, 0);
        send_sample(100, 20, 0);
        send_sample(0, 20, 3);
        send_sample(1, 20, 0);
        pause_sender(1);
    endtask

    // Down factor zero decides every sample; a factor of three skips two of three.
    task automatic test_down_factor();
        write_settings(90, 60, 10, 0, 0, 100000);
        send_sample(10, 90000, 0);
        send_sample(10, 90000, 0);
        pause_sender(1);
        write_settings(90, 60, 10, 3, 0, 100000);
        repeat (4) send_sample(10, 90000, 0);
        send_sample(95, 90000, 0);
        send_sample(10, 90000, 0);
        pause_sender(1);
    endtask

    // Zero step percent freezes the governor whatever the load.
    task automatic test_frozen();
        write_settings(80, 20, 0, 1, 0, FREQ_MASK);
        send_sample(100, 4000000, 0);
        send_sample(0, 4000000, 65535);
        pause_sender(1);
    endtask

    task automatic pick_random_settings();
        int unsigned up, down, pct, factor, lo, hi, r;
        up = $urandom_range(1, 100);
        down = $urandom_range(1, 99);
        r = $urandom_range(9);
        pct = (r == 0) ? 0 : (r == 1) ? $urandom_range(101, 127)
            : (r < 6) ? $urandom_range(1, 15) : $urandom_range(1, 100);
        r = $urandom_range(9);
        factor = (r == 0) ? 0 : (r == 1) ? $urandom_range(11, 15) : $urandom_range(1, 10);
        r = $urandom_range(9);
        hi = (r < 5) ? $urandom_range(1000, 100000) : (r < 7) ? $urandom_range(FREQ_MASK)
           : (r == 7) ? FREQ_MASK : (r == 8) ? $urandom_range(200) : 0;
        r = $urandom_range(9);
        lo = (r < 7) ? $urandom_range(hi / 2) : (r == 7) ? 0 : $urandom_range(FREQ_MASK);
        write_settings(up, down, pct, factor, lo, hi);
    endtask

    // Loads are steered mostly past the thresholds so the request really moves.
    task automatic send_random_sample();
        int unsigned load, cur, idle, r, lo, hi, up, down;
        lo = gov_cfg.min_freq;
        hi = gov_cfg.max_freq;
        up = gov_cfg.up_thr;
        down = gov_cfg.down_thr;
        r = $urandom_range(9);
        if (r < 4) begin
            load = (up >= 100) ? 100 : $urandom_range(up + 1, 100);
        end else if (r < 7) begin
            load = (down == 0) ? 0 : $urandom_range(0, down - 1);
        end else begin
            load = $urandom_range(100);
        end
        r = $urandom_range(9);
        cur = (r < 8 && lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(FREQ_MASK);
        r = $urandom_range(19);
        idle = (r < 15) ? 0 : (r < 18) ? $urandom_range(1, 3)
             : (r == 18) ? $urandom_range(65535) : 65535;
        send_sample(load, cur, idle);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0) begin
                r = $urandom_range(gap_max);
                if (r > 0) pause_sender(r);
            end
        end
        burst_left--;
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_settings(1, 1, 1, 1, 0, FREQ_MASK);
                1: write_settings(100, 99, 100, 10, FREQ_MASK, FREQ_MASK);
                default: pick_random_settings();
            endcase
            if (phase == 2) begin
                gap_max = 0;
                stall_pct = 0;
            end else begin
                gap_max = $urandom_range(1, 8);
                stall_pct = 20 * $urandom_range(1, 4);
                stall_run_max = $urandom_range(1, 12);
            end
            repeat (PHASE_SAMPLES) send_random_sample();
            pause_sender(1);
        end
    endtask

    initial begin
        gov_cfg = '{RST_UP_THR, RST_DOWN_THR, RST_STEP_PCT, RST_DOWN_FACTOR,
                    RST_MIN_FREQ, RST_MAX_FREQ};
        gov_req = '0;
        gov_skip = '0;
        gov_started = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_first_sample();
        test_bounds();
        test_fallback_step();
        test_down_factor();
        test_frozen();
        test_random_settings();

        while (expected_decisions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d load samples under %0d register settings; %0d asked for a new target.",
                 samples_sent, settings_used, requests_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d decisions outstanding.", expected_decisions.size());
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/cds_pkg.sv
sv/cds_front.sv
sv/cds_back.sv
sv/conservative_dvfs_stepper.sv
bench/conservative_dvfs_stepper_tb.sv
